// ===== src/btr_pkg.sv =====
package btr_pkg;

    localparam int NUM_W    = 12;
    localparam int DIG_W    = 4;
    localparam int NUM_DIGS = 4;
    localparam int BCD_W    = DIG_W * NUM_DIGS;
    localparam int LET_W    = 8;
    localparam int CNT_W    = $clog2(NUM_W + 1);

    localparam logic [NUM_W-1:0] MAX_VALID = NUM_W'(3999);

    localparam logic [LET_W-1:0] CH_I    = 8'h49;
    localparam logic [LET_W-1:0] CH_V    = 8'h56;
    localparam logic [LET_W-1:0] CH_X    = 8'h58;
    localparam logic [LET_W-1:0] CH_L    = 8'h4C;
    localparam logic [LET_W-1:0] CH_C    = 8'h43;
    localparam logic [LET_W-1:0] CH_D    = 8'h44;
    localparam logic [LET_W-1:0] CH_M    = 8'h4D;
    localparam logic [LET_W-1:0] CH_NONE = 8'h00;

    typedef enum logic [1:0] {
        SEL_ONE  = 2'd0,
        SEL_FIVE = 2'd1,
        SEL_TEN  = 2'd2
    } sym_sel_t;

    typedef struct packed {
        logic             load;
        logic             oor;
        logic [BCD_W-1:0] digits;
    } btr_digits_t;

    function automatic logic [2:0] digit_len(input logic [DIG_W-1:0] d);
        logic [2:0] n;
        case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic sym_sel_t digit_sel(input logic [DIG_W-1:0] d, input logic [1:0] pos);
        sym_sel_t s;
        s = SEL_ONE;
        if (d == 4'd4)
        begin
            s = (pos == 2'd0) ? SEL_ONE : SEL_FIVE;
        end
        else if (d == 4'd9)
        begin
            s = (pos == 2'd0) ? SEL_ONE : SEL_TEN;
        end
        else if (d inside {[4'd5:4'd8]})
        begin
            s = (pos == 2'd0) ? SEL_FIVE : SEL_ONE;
        end
        return s;
    endfunction

    function automatic logic [LET_W-1:0] place_sym(input logic [1:0] place, input sym_sel_t sel);
        logic [LET_W-1:0] c;
        c = CH_NONE;
        case (place)
            2'd0:
            begin
                case (sel)
                    SEL_ONE:  c = CH_I;
                    SEL_FIVE: c = CH_V;
                    SEL_TEN:  c = CH_X;
                    default:  c = CH_NONE;
                endcase
            end
            2'd1:
            begin
                case (sel)
                    SEL_ONE:  c = CH_X;
                    SEL_FIVE: c = CH_L;
                    SEL_TEN:  c = CH_C;
                    default:  c = CH_NONE;
                endcase
            end
            2'd2:
            begin
                case (sel)
                    SEL_ONE:  c = CH_C;
                    SEL_FIVE: c = CH_D;
                    SEL_TEN:  c = CH_M;
                    default:  c = CH_NONE;
                endcase
            end
            2'd3:
            begin
                c = (sel == SEL_ONE) ? CH_M : CH_NONE;
            end
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

// ===== src/btr_bcd.sv =====
module btr_bcd
    import btr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    number,
    output logic                busy,
    output btr_digits_t         dig
);

    logic [NUM_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             load_reg, load_next;
    logic             oor_reg, oor_next;
    logic [BCD_W-1:0] adj;

    // add-3 on each digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGS; i++)
        begin
            adj[i*DIG_W +: DIG_W] = (bcd_reg[i*DIG_W +: DIG_W] >= 4'd5)
                ? bcd_reg[i*DIG_W +: DIG_W] + 4'd3
                : bcd_reg[i*DIG_W +: DIG_W];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        load_next = 1'b0;
        oor_next  = oor_reg;
        if (start && !busy_reg)
        begin
            bin_next  = number;
            bcd_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
            oor_next  = (number == '0) || (number > MAX_VALID);
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[NUM_W-1]};
            bin_next = {bin_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                load_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            load_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            load_reg <= load_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        oor_reg <= oor_next;
    end

    assign busy       = busy_reg;
    assign dig.load   = load_reg;
    assign dig.oor    = oor_reg;
    assign dig.digits = bcd_reg;

endmodule

// ===== src/btr_emit.sv =====
module btr_emit
    import btr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  btr_digits_t        dig,
    output logic               active,
    output logic               result_valid,
    output logic [LET_W-1:0]   letter,
    output logic               last_letter,
    output logic               out_of_range
);

    logic [BCD_W-1:0] dig_reg, dig_next;
    logic [1:0]       place_reg, place_next;
    logic [1:0]       pos_reg, pos_next;
    logic             active_reg, active_next;
    logic             oor_reg, oor_next;
    logic             strobe_reg, strobe_next;
    logic [LET_W-1:0] letter_reg, letter_next;
    logic             last_reg, last_next;
    logic             oorout_reg, oorout_next;

    logic [DIG_W-1:0] cur;
    logic [2:0]       len;
    logic             digit_end;
    logic             final_let;

    assign cur       = dig_reg[BCD_W-1 -: DIG_W];
    assign len       = digit_len(cur);
    assign digit_end = (len == 3'd0) || ({1'b0, pos_reg} == len - 3'd1);
    assign final_let = digit_end && (len != 3'd0) && (dig_reg[BCD_W-DIG_W-1:0] == '0);

    always_comb
    begin
        dig_next    = dig_reg;
        place_next  = place_reg;
        pos_next    = pos_reg;
        active_next = active_reg;
        oor_next    = oor_reg;
        strobe_next = 1'b0;
        letter_next = letter_reg;
        last_next   = last_reg;
        oorout_next = oorout_reg;
        if (dig.load)
        begin
            dig_next    = dig.digits;
            place_next  = 2'd3;
            pos_next    = 2'd0;
            active_next = 1'b1;
            oor_next    = dig.oor;
        end
        else if (active_reg)
        begin
            if (oor_reg)
            begin
                strobe_next = 1'b1;
                letter_next = CH_NONE;
                last_next   = 1'b1;
                oorout_next = 1'b1;
                active_next = 1'b0;
            end
            else
            begin
                if (len != 3'd0)
                begin
                    strobe_next = 1'b1;
                    letter_next = place_sym(place_reg, digit_sel(cur, pos_reg));
                    last_next   = final_let;
                    oorout_next = 1'b0;
                end
                if (digit_end)
                begin
                    dig_next   = {dig_reg[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    place_next = place_reg - 2'd1;
                    pos_next   = 2'd0;
                end
                else
                begin
                    pos_next = pos_reg + 2'd1;
                end
                if (final_let)
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg    <= dig_next;
        place_reg  <= place_next;
        pos_reg    <= pos_next;
        oor_reg    <= oor_next;
        letter_reg <= letter_next;
        last_reg   <= last_next;
        oorout_reg <= oorout_next;
    end

    assign active       = active_reg;
    assign result_valid = strobe_reg;
    assign letter       = letter_reg;
    assign last_letter  = last_reg;
    assign out_of_range = oorout_reg;

endmodule

// ===== src/binary_to_roman_numeral.sv =====
// Conversion: bit-serial binary-to-BCD shifting of all 12 bits of number, then
// the BCD digits are walked from thousands down with one strobe per letter; a zero
// decimal digit ahead of the last letter is stepped over with no strobe. Zero or a
// number above 3999 gives a single strobe with out_of_range and no letter.
// Busy holds off start until the last letter of a number is strobed.
// The receiver cannot stall; each result is shown for one cycle only.
// Reset: rst_n asynchronous, active low; clears busy and the result strobe.
module binary_to_roman_numeral
    import btr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   number,
    output logic               busy,
    output logic               result_valid,
    output logic [LET_W-1:0]   letter,
    output logic               last_letter,
    output logic               out_of_range
);

    btr_digits_t dig;
    logic        bcd_busy;
    logic        emit_active;
    logic        start_ok;

    assign start_ok = start && !busy;

    btr_bcd u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_ok),
        .number (number),
        .busy   (bcd_busy),
        .dig    (dig)
    );

    btr_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .dig          (dig),
        .active       (emit_active),
        .result_valid (result_valid),
        .letter       (letter),
        .last_letter  (last_letter),
        .out_of_range (out_of_range)
    );

    assign busy = bcd_busy || dig.load || emit_active;

endmodule

// ===== src/btr_chk.sv =====
module btr_chk
    import btr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   number,
    input  logic               busy,
    input  logic               result_valid,
    input  logic [LET_W-1:0]   letter,
    input  logic               last_letter,
    input  logic               out_of_range
);

    // a result only comes out of a conversion in flight
    a_valid_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without conversion in flight");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after start transfer");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && out_of_range) |-> (last_letter && letter == CH_NONE))
        else $error("error result malformed");

    a_letter_set: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !out_of_range) |->
            (letter == CH_I || letter == CH_V || letter == CH_X || letter == CH_L ||
             letter == CH_C || letter == CH_D || letter == CH_M))
        else $error("letter outside symbol set");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && number != '0 && number <= MAX_VALID) |=> !out_of_range || !result_valid)
        else $error("error flagged right after valid start");

endmodule

bind binary_to_roman_numeral btr_chk u_btr_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .number       (number),
    .busy         (busy),
    .result_valid (result_valid),
    .letter       (letter),
    .last_letter  (last_letter),
    .out_of_range (out_of_range)
);

// ===== dv/binary_to_roman_numeral_tb.sv =====
module binary_to_roman_numeral_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import btr_pkg::*;

    typedef struct packed {
        logic [LET_W-1:0] letter;
        logic             last;
        logic             oor;
    } roman_sym_t;

    localparam logic [LET_W-1:0] UNIT_SYM [4] = '{CH_I, CH_X, CH_C, CH_M};
    localparam logic [LET_W-1:0] FIVE_SYM [4] = '{CH_V, CH_L, CH_D, CH_NONE};
    localparam logic [LET_W-1:0] TEN_SYM  [4] = '{CH_X, CH_C, CH_M, CH_NONE};

    logic             clk;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [NUM_W-1:0] number = '0;
    logic             busy;
    logic             result_valid;
    logic [LET_W-1:0] letter;
    logic             last_letter;
    logic             out_of_range;

    logic [NUM_W-1:0] pending_numbers [$];
    roman_sym_t       roman_q [$];
    int               idle_cycles = 0;
    bit               no_idle = 1'b0;
    int               errors = 0;

    binary_to_roman_numeral dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .number       (number),
        .busy         (busy),
        .result_valid (result_valid),
        .letter       (letter),
        .last_letter  (last_letter),
        .out_of_range (out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void push_letter(input logic [LET_W-1:0] sym);
        roman_sym_t s;
        s.letter = sym;
        s.last   = 1'b0;
        s.oor    = 1'b0;
        roman_q.push_back(s);
    endfunction

    // Expected letter run for one number, most significant digit first.
    function automatic void predict_roman(input logic [NUM_W-1:0] value);
        int         digit [4];
        int         v;
        roman_sym_t s;
        v = int'(value);
        if (v == 0 || value > MAX_VALID)
        begin
            s.letter = CH_NONE;
            s.last   = 1'b1;
            s.oor    = 1'b1;
            roman_q.push_back(s);
            return;
        end
        digit[3] = v / 1000;
        digit[2] = (v / 100) % 10;
        digit[1] = (v / 10) % 10;
        digit[0] = v % 10;
        for (int place = 3; place >= 0; place--)
        begin
            if (digit[place] == 9)
            begin
                push_letter(UNIT_SYM[place]);
                push_letter(TEN_SYM[place]);
            end
            else if (digit[place] == 4)
            begin
                push_letter(UNIT_SYM[place]);
                push_letter(FIVE_SYM[place]);
            end
            else
            begin
                if (digit[place] >= 5)
                    push_letter(FIVE_SYM[place]);
                for (int k = 0; k < digit[place] % 5; k++)
                    push_letter(UNIT_SYM[place]);
            end
        end
        roman_q[roman_q.size() - 1].last = 1'b1;
    endfunction

    // Mostly short gaps, a few long ones, with occasional back-to-back stretches.
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 99) < 3)
            no_idle = ~no_idle;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Driver: a transfer happens at an edge with start high and busy low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_roman(number);
                idle_cycles = pick_gap();
            end
            if (!(start && busy))
            begin
                if (idle_cycles > 0)
                begin
                    start  <= 1'b0;
                    number <= NUM_W'($urandom);
                    idle_cycles--;
                end
                else if (pending_numbers.size() > 0)
                begin
                    start  <= 1'b1;
                    number <= pending_numbers.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results cannot be held off, so every strobe is checked.
    always @(posedge clk)
    begin
        roman_sym_t want;
        if (rst_n && result_valid)
        begin
            if (roman_q.size() == 0)
            begin
                $display("%0t: unexpected result letter %h last %b oor %b",
                         $realtime, letter, last_letter, out_of_range);
                errors++;
            end
            else
            begin
                want = roman_q.pop_front();
                if (letter !== want.letter)
                begin
                    $display("%0t: letter expected %h actual %h",
                             $realtime, want.letter, letter);
                    errors++;
                end
                if (last_letter !== want.last)
                begin
                    $display("%0t: last_letter expected %b actual %b",
                             $realtime, want.last, last_letter);
                    errors++;
                end
                if (out_of_range !== want.oor)
                begin
                    $display("%0t: out_of_range expected %b actual %b",
                             $realtime, want.oor, out_of_range);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int directed [];
        directed = '{0, 1, 4, 5, 9, 10, 14, 40, 49, 90, 99, 400, 444, 499,
                     900, 999, 1000, 1994, 2048, 3000, 3888, 3999, 4000,
                     4095, 2730};
        foreach (directed[i])
            pending_numbers.push_back(NUM_W'(directed[i]));
        repeat (500)
        begin
            case ($urandom_range(0, 19))
                0:       pending_numbers.push_back('0);
                1, 2:    pending_numbers.push_back(NUM_W'($urandom_range(4000, 4095)));
                3:       pending_numbers.push_back(NUM_W'($urandom_range(1, 30)));
                4:       pending_numbers.push_back(NUM_W'($urandom_range(3980, 3999)));
                default: pending_numbers.push_back(NUM_W'($urandom_range(1, 3999)));
            endcase
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_numbers.size() != 0 || start || roman_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("binary_to_roman_numeral: match");
        else
            $display("binary_to_roman_numeral: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("binary_to_roman_numeral: mismatch");
        $finish;
    end

endmodule
